// ----- src/btci_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// btci_pkg
// Shared types, constants and the operation sequence of the barycentric
// texture coordinate interpolator.
// ----------------------------------------------------------------------------
package btci_pkg;

    // Working width: every intermediate value of the query fits in 176 bits.
    localparam int WIDE_W    = 176;
    // Second operand of a product: 68-bit signed (coordinate differences,
    // normal components and cross product components).
    localparam int MUL_B_W   = 68;
    localparam int RF_DEPTH  = 32;
    localparam int ADDR_W    = 5;
    localparam int STEP_W    = 8;
    localparam int PC_W      = 7;
    localparam int NUM_UOPS  = 77;
    localparam int COORD_W   = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PC_W-1:0]   pc_t;
    typedef logic [2:0]        field_t;
    typedef logic [1:0]        mode_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam mode_t MODE_A     = 2'd0;
    localparam mode_t MODE_B     = 2'd1;
    localparam mode_t MODE_C     = 2'd2;
    localparam mode_t MODE_QUERY = 2'd3;

    localparam field_t FLD_X = 3'd0;
    localparam field_t FLD_Y = 3'd1;
    localparam field_t FLD_Z = 3'd2;
    localparam field_t FLD_U = 3'd3;
    localparam field_t FLD_V = 3'd4;

    localparam addr_t ADDR_VA = 5'd0;
    localparam addr_t ADDR_VB = 5'd5;
    localparam addr_t ADDR_VC = 5'd10;
    localparam addr_t ADDR_P  = 5'd15;

    localparam pc_t LAST_PC = pc_t'(NUM_UOPS - 1);

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_LDF  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5,
        OP_FIN  = 3'd6
    } op_t;

    typedef struct packed {
        op_t   op;
        addr_t d;
        addr_t a;
        addr_t b;
        logic  chk;
    } uop_t;

    typedef struct packed {
        logic   capture;
        logic   start;
        op_t    op;
        field_t field_sel;
        addr_t  rd_a;
        addr_t  rd_b;
        addr_t  wr_addr;
        logic   out_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic zero;
        logic out_valid;
    } dp_sts_t;

    function automatic uop_t mk(input op_t op, input int d, input int a, input int b);
        uop_t r;
        r.op  = op;
        r.d   = ADDR_W'(d);
        r.a   = ADDR_W'(a);
        r.b   = ADDR_W'(b);
        r.chk = 1'b0;
        return r;
    endfunction

    // Register map: A 0..4, B 5..9, C 10..14 (x,y,z,u,v), P 15..17,
    // scratch 18..31. For the final step d selects u (0) or v (1).
    function automatic uop_t uop_rom(input pc_t pc);
        uop_t r;
        r = mk(OP_NONE, 0, 0, 0);
        case (pc)
            // ab = B - A, ac = C - A
            7'd0:  r = mk(OP_SUB, 18, 5, 0);
            7'd1:  r = mk(OP_SUB, 19, 6, 1);
            7'd2:  r = mk(OP_SUB, 20, 7, 2);
            7'd3:  r = mk(OP_SUB, 21, 10, 0);
            7'd4:  r = mk(OP_SUB, 22, 11, 1);
            7'd5:  r = mk(OP_SUB, 23, 12, 2);
            // n = ab x ac
            7'd6:  r = mk(OP_MUL, 24, 19, 23);
            7'd7:  r = mk(OP_MUL, 25, 20, 22);
            7'd8:  r = mk(OP_SUB, 26, 24, 25);
            7'd9:  r = mk(OP_MUL, 24, 20, 21);
            7'd10: r = mk(OP_MUL, 25, 18, 23);
            7'd11: r = mk(OP_SUB, 27, 24, 25);
            7'd12: r = mk(OP_MUL, 24, 18, 22);
            7'd13: r = mk(OP_MUL, 25, 19, 21);
            7'd14: r = mk(OP_SUB, 28, 24, 25);
            // den = n . n
            7'd15: r = mk(OP_MUL, 24, 26, 26);
            7'd16: r = mk(OP_MUL, 25, 27, 27);
            7'd17: r = mk(OP_ADD, 24, 24, 25);
            7'd18: r = mk(OP_MUL, 25, 28, 28);
            7'd19:
            begin
                r = mk(OP_ADD, 29, 24, 25);
                r.chk = 1'b1;
            end
            // bp = B - P, cp = C - P
            7'd20: r = mk(OP_SUB, 18, 5, 15);
            7'd21: r = mk(OP_SUB, 19, 6, 16);
            7'd22: r = mk(OP_SUB, 20, 7, 17);
            7'd23: r = mk(OP_SUB, 21, 10, 15);
            7'd24: r = mk(OP_SUB, 22, 11, 16);
            7'd25: r = mk(OP_SUB, 23, 12, 17);
            // pa = n . (bp x cp)
            7'd26: r = mk(OP_MUL, 24, 19, 23);
            7'd27: r = mk(OP_MUL, 25, 20, 22);
            7'd28: r = mk(OP_SUB, 30, 24, 25);
            7'd29: r = mk(OP_MUL, 31, 26, 30);
            7'd30: r = mk(OP_MUL, 24, 20, 21);
            7'd31: r = mk(OP_MUL, 25, 18, 23);
            7'd32: r = mk(OP_SUB, 30, 24, 25);
            7'd33: r = mk(OP_MUL, 24, 27, 30);
            7'd34: r = mk(OP_ADD, 31, 31, 24);
            7'd35: r = mk(OP_MUL, 24, 18, 22);
            7'd36: r = mk(OP_MUL, 25, 19, 21);
            7'd37: r = mk(OP_SUB, 30, 24, 25);
            7'd38: r = mk(OP_MUL, 24, 28, 30);
            7'd39: r = mk(OP_ADD, 31, 31, 24);
            // ap = A - P
            7'd40: r = mk(OP_SUB, 18, 0, 15);
            7'd41: r = mk(OP_SUB, 19, 1, 16);
            7'd42: r = mk(OP_SUB, 20, 2, 17);
            // pb = n . (cp x ap)
            7'd43: r = mk(OP_MUL, 24, 22, 20);
            7'd44: r = mk(OP_MUL, 25, 23, 19);
            7'd45: r = mk(OP_SUB, 30, 24, 25);
            7'd46: r = mk(OP_MUL, 15, 26, 30);
            7'd47: r = mk(OP_MUL, 24, 23, 18);
            7'd48: r = mk(OP_MUL, 25, 21, 20);
            7'd49: r = mk(OP_SUB, 30, 24, 25);
            7'd50: r = mk(OP_MUL, 24, 27, 30);
            7'd51: r = mk(OP_ADD, 15, 15, 24);
            7'd52: r = mk(OP_MUL, 24, 21, 19);
            7'd53: r = mk(OP_MUL, 25, 22, 18);
            7'd54: r = mk(OP_SUB, 30, 24, 25);
            7'd55: r = mk(OP_MUL, 24, 28, 30);
            7'd56: r = mk(OP_ADD, 15, 15, 24);
            // u: t = 2*(pa*(uA-uC) + pb*(uB-uC)) + den, q = floor(t / 2den)
            7'd57: r = mk(OP_SUB, 16, 3, 13);
            7'd58: r = mk(OP_SUB, 17, 8, 13);
            7'd59: r = mk(OP_MUL, 24, 31, 16);
            7'd60: r = mk(OP_MUL, 25, 15, 17);
            7'd61: r = mk(OP_ADD, 24, 24, 25);
            7'd62: r = mk(OP_ADD, 24, 24, 24);
            7'd63: r = mk(OP_ADD, 24, 24, 29);
            7'd64: r = mk(OP_ADD, 25, 29, 29);
            7'd65: r = mk(OP_DIV, 24, 24, 25);
            7'd66: r = mk(OP_FIN, 0, 24, 13);
            // v
            7'd67: r = mk(OP_SUB, 16, 4, 14);
            7'd68: r = mk(OP_SUB, 17, 9, 14);
            7'd69: r = mk(OP_MUL, 24, 31, 16);
            7'd70: r = mk(OP_MUL, 25, 15, 17);
            7'd71: r = mk(OP_ADD, 24, 24, 25);
            7'd72: r = mk(OP_ADD, 24, 24, 24);
            7'd73: r = mk(OP_ADD, 24, 24, 29);
            7'd74: r = mk(OP_ADD, 25, 29, 29);
            7'd75: r = mk(OP_DIV, 24, 24, 25);
            7'd76: r = mk(OP_FIN, 1, 24, 14);
            default: r = mk(OP_NONE, 0, 0, 0);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/btci_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// btci_if
// Valid/ready channels: input words (vertex loads and queries) and result
// words.
// ----------------------------------------------------------------------------
interface btci_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;

    modport source (output valid, mode, pos_x, pos_y, pos_z, tex_u, tex_v,
                    input ready);
    modport sink (input valid, mode, pos_x, pos_y, pos_z, tex_u, tex_v,
                  output ready);
endinterface

interface btci_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_u;
    logic signed [31:0] out_v;
    logic               ok;

    modport source (output valid, out_u, out_v, ok, input ready);
    modport sink (input valid, out_u, out_v, ok, output ready);
endinterface
`default_nettype wire

// ----- src/btci_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// btci_ctrl
// Sequencer: takes input words, stores vertices, and steps the datapath
// through the query operation list.
// ----------------------------------------------------------------------------
module btci_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire btci_pkg::mode_t   item_mode,
    output logic                   item_ready,
    output btci_pkg::dp_cmd_t      cmd,
    input  wire btci_pkg::dp_sts_t sts
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_PNT  = 7'b0000100,
        S_READ = 7'b0001000,
        S_EXEC = 7'b0010000,
        S_WAIT = 7'b0100000,
        S_FAIL = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    btci_pkg::pc_t     pc_reg, pc_next;
    btci_pkg::field_t  cnt_reg, cnt_next;
    logic [2:0]        mask_reg, mask_next;
    btci_pkg::mode_t   mode_reg, mode_next;
    btci_pkg::uop_t    uop;
    btci_pkg::addr_t   vtx_base;

    always_comb
    begin
        unique case (mode_reg)
            btci_pkg::MODE_A: vtx_base = btci_pkg::ADDR_VA;
            btci_pkg::MODE_B: vtx_base = btci_pkg::ADDR_VB;
            btci_pkg::MODE_C: vtx_base = btci_pkg::ADDR_VC;
            default:          vtx_base = btci_pkg::ADDR_P;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        cnt_next      = cnt_reg;
        mask_next     = mask_reg;
        mode_next     = mode_reg;
        item_ready    = 1'b0;
        uop           = btci_pkg::uop_rom(pc_reg);
        cmd           = '0;
        cmd.op        = btci_pkg::OP_NONE;
        cmd.rd_a      = uop.a;
        cmd.rd_b      = uop.b;
        cmd.field_sel = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    mode_next   = item_mode;
                    cnt_next    = btci_pkg::FLD_X;
                    if (item_mode == btci_pkg::MODE_QUERY)
                    begin
                        state_next = (mask_reg == 3'b111) ? S_PNT : S_FAIL;
                    end
                    else
                    begin
                        mask_next  = mask_reg | (3'b001 << item_mode);
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.start   = 1'b1;
                cmd.op      = btci_pkg::OP_LDF;
                cmd.wr_addr = vtx_base + btci_pkg::ADDR_W'(cnt_reg);
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == btci_pkg::FLD_V)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PNT:
            begin
                cmd.start   = 1'b1;
                cmd.op      = btci_pkg::OP_LDF;
                cmd.wr_addr = btci_pkg::ADDR_P + btci_pkg::ADDR_W'(cnt_reg);
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == btci_pkg::FLD_Z)
                begin
                    pc_next    = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // hold the final step until the result register is free
                if (!(uop.op == btci_pkg::OP_FIN && sts.out_valid))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.start   = 1'b1;
                cmd.op      = uop.op;
                cmd.wr_addr = uop.d;
                if (uop.op == btci_pkg::OP_MUL || uop.op == btci_pkg::OP_DIV)
                begin
                    state_next = S_WAIT;
                end
                else if (uop.chk && sts.zero)
                begin
                    state_next = S_FAIL;
                end
                else if (pc_reg == btci_pkg::LAST_PC)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    pc_next    = pc_reg + 7'd1;
                    state_next = S_READ;
                end
            end
            S_WAIT:
            begin
                if (!sts.busy)
                begin
                    pc_next    = pc_reg + 7'd1;
                    state_next = S_READ;
                end
            end
            S_FAIL:
            begin
                if (!sts.out_valid)
                begin
                    cmd.out_clear = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
            mask_reg  <= '0;
            mode_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            mask_reg  <= mask_next;
            mode_reg  <= mode_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/btci_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// btci_dp
// Datapath: operand memory, adder, bit-serial multiplier, restoring divider
// and the result register with wrap and saturation.
// ----------------------------------------------------------------------------
module btci_dp #(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire btci_pkg::dp_cmd_t  cmd,
    output btci_pkg::dp_sts_t       sts,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [31:0] tex_u,
    input  wire logic signed [31:0] tex_v,
    input  wire logic               cfg_write,
    input  wire logic               cfg_data,
    output logic signed [31:0]      out_u,
    output logic signed [31:0]      out_v,
    output logic                    ok,
    output logic                    out_valid,
    input  wire logic               out_ready
);

    localparam int W = btci_pkg::WIDE_W;
    localparam int B = btci_pkg::MUL_B_W;

    btci_pkg::wide_t rf_mem [btci_pkg::RF_DEPTH];
    btci_pkg::wide_t opa_reg, opb_reg;

    logic signed [31:0] hold_x_reg, hold_y_reg, hold_z_reg, hold_u_reg, hold_v_reg;
    logic signed [31:0] field_val;

    logic                        wrap_reg;
    logic                        mul_busy_reg, div_busy_reg;
    logic [btci_pkg::STEP_W-1:0] step_reg;
    btci_pkg::addr_t             dst_reg;
    btci_pkg::wide_t             mcand_reg, acc_reg, acc_step;
    logic [B-1:0]                mplier_reg;
    logic                        neg_reg;
    logic [W-1:0]                num_reg, rem_reg, den_reg, num_step, rem_step, quot;
    logic [W:0]                  rem_sh;
    logic                        rem_ge;

    btci_pkg::wide_t alu_res;
    logic            fits;
    logic [31:0]     fin_val;

    logic            wr_en;
    btci_pkg::addr_t wr_addr;
    btci_pkg::wide_t wr_data;

    logic            mul_last, div_last;
    logic signed [31:0] out_u_reg, out_v_reg;
    logic            ok_reg, out_valid_reg;

    // ALU: add, or subtract for OP_SUB
    always_comb
    begin
        if (cmd.op == btci_pkg::OP_SUB)
        begin
            alu_res = opa_reg - opb_reg;
        end
        else
        begin
            alu_res = opa_reg + opb_reg;
        end
    end

    always_comb
    begin
        case (cmd.field_sel)
            btci_pkg::FLD_X: field_val = hold_x_reg;
            btci_pkg::FLD_Y: field_val = hold_y_reg;
            btci_pkg::FLD_Z: field_val = hold_z_reg;
            btci_pkg::FLD_U: field_val = hold_u_reg;
            default:         field_val = hold_v_reg;
        endcase
    end

    // multiplier: one bit of the second operand per cycle, top bit weighs negative
    assign mul_last = (step_reg == btci_pkg::STEP_W'(B - 1));
    always_comb
    begin
        acc_step = acc_reg;
        if (mplier_reg[0])
        begin
            acc_step = mul_last ? (acc_reg - mcand_reg) : (acc_reg + mcand_reg);
        end
    end

    // divider: one quotient bit per cycle, then a final step that applies the sign
    assign div_last = (step_reg == btci_pkg::STEP_W'(W));
    assign rem_sh   = {rem_reg, num_reg[W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});
    always_comb
    begin
        rem_step = rem_ge ? W'(rem_sh - {1'b0, den_reg}) : rem_sh[W-1:0];
        num_step = {num_reg[W-2:0], rem_ge};
        quot     = neg_reg ? (~num_reg + W'(1)) : num_reg;
    end

    // final rounding result: wrap to the fraction or saturate to 32 bits
    assign fits = (&alu_res[W-1:31]) | ~(|alu_res[W-1:31]);
    always_comb
    begin
        if (wrap_reg)
        begin
            fin_val = 32'(alu_res[FRAC_BITS-1:0]);
        end
        else if (fits)
        begin
            fin_val = alu_res[31:0];
        end
        else
        begin
            fin_val = alu_res[W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmd.wr_addr;
        wr_data = alu_res;
        if (cmd.start && cmd.op == btci_pkg::OP_LDF)
        begin
            wr_en   = 1'b1;
            wr_data = {{(W-32){field_val[31]}}, field_val};
        end
        else if (cmd.start && (cmd.op == btci_pkg::OP_ADD || cmd.op == btci_pkg::OP_SUB))
        begin
            wr_en = 1'b1;
        end
        else if (mul_busy_reg && mul_last)
        begin
            wr_en   = 1'b1;
            wr_addr = dst_reg;
            wr_data = acc_step;
        end
        else if (div_busy_reg && div_last)
        begin
            wr_en   = 1'b1;
            wr_addr = dst_reg;
            wr_data = quot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_addr] <= wr_data;
        end
        opa_reg <= rf_mem[cmd.rd_a];
        opb_reg <= rf_mem[cmd.rd_b];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hold_x_reg <= pos_x;
            hold_y_reg <= pos_y;
            hold_z_reg <= pos_z;
            hold_u_reg <= tex_u;
            hold_v_reg <= tex_v;
        end
        if (cmd.start && cmd.op == btci_pkg::OP_MUL)
        begin
            mcand_reg  <= opa_reg;
            mplier_reg <= opb_reg[B-1:0];
            acc_reg    <= '0;
            dst_reg    <= cmd.wr_addr;
        end
        else if (cmd.start && cmd.op == btci_pkg::OP_DIV)
        begin
            // negative dividend: floor(t/d) = -((d - 1 - t) / d)
            neg_reg <= opa_reg[W-1];
            num_reg <= opa_reg[W-1] ? W'(~opa_reg + opb_reg) : opa_reg;
            den_reg <= opb_reg;
            rem_reg <= '0;
            dst_reg <= cmd.wr_addr;
        end
        else if (mul_busy_reg)
        begin
            acc_reg    <= acc_step;
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
        else if (div_busy_reg && !div_last)
        begin
            rem_reg <= rem_step;
            num_reg <= num_step;
        end
        if (cmd.start && cmd.op == btci_pkg::OP_FIN)
        begin
            if (cmd.wr_addr[0])
            begin
                out_v_reg <= fin_val;
            end
            else
            begin
                out_u_reg <= fin_val;
            end
        end
        else if (cmd.out_clear)
        begin
            out_u_reg <= '0;
            out_v_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg      <= 1'b0;
            mul_busy_reg  <= 1'b0;
            div_busy_reg  <= 1'b0;
            step_reg      <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                wrap_reg <= cfg_data;
            end
            if (cmd.start && cmd.op == btci_pkg::OP_MUL)
            begin
                mul_busy_reg <= 1'b1;
                step_reg     <= '0;
            end
            else if (cmd.start && cmd.op == btci_pkg::OP_DIV)
            begin
                div_busy_reg <= 1'b1;
                step_reg     <= '0;
            end
            else if (mul_busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (mul_last)
                begin
                    mul_busy_reg <= 1'b0;
                end
            end
            else if (div_busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (div_last)
                begin
                    div_busy_reg <= 1'b0;
                end
            end
            if (cmd.start && cmd.op == btci_pkg::OP_FIN && cmd.wr_addr[0])
            begin
                ok_reg        <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (cmd.out_clear)
            begin
                ok_reg        <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.busy      = mul_busy_reg | div_busy_reg;
    assign sts.zero      = (alu_res == '0);
    assign sts.out_valid = out_valid_reg;

    assign out_u     = out_u_reg;
    assign out_v     = out_v_reg;
    assign ok        = ok_reg;
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ----- src/barycentric_texcoord_interp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// barycentric_texcoord_interp
// Texture coordinate of a point on a triangle from barycentric weights.
// ----------------------------------------------------------------------------
// Vertex load: the five fields are written in turn before the next word is taken.
// Query: its length is set by the bit-serial multiplier (68-bit second operand,
// 31 products) and the restoring divider (176 quotient bits, two divisions).
// One word is worked on at a time; a finished result waits in the output
// register while the next word is taken.
// Reset clears control state, the loaded-vertex mask and the wrap setting.
module barycentric_texcoord_interp #(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    btci_item_if.sink      item,
    btci_result_if.source  result,
    input  wire logic      cfg_write,
    input  wire logic      cfg_data
);

    btci_pkg::dp_cmd_t cmd;
    btci_pkg::dp_sts_t sts;

    btci_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_mode  (item.mode),
        .item_ready (item.ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    btci_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .pos_x     (item.pos_x),
        .pos_y     (item.pos_y),
        .pos_z     (item.pos_z),
        .tex_u     (item.tex_u),
        .tex_v     (item.tex_v),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .out_u     (result.out_u),
        .out_v     (result.out_v),
        .ok        (result.ok),
        .out_valid (result.valid),
        .out_ready (result.ready)
    );

endmodule
`default_nettype wire

// ----- tb/barycentric_texcoord_interp_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// barycentric_texcoord_interp_tb
// Self-checking bench for the texture coordinate interpolator. It runs a
// directed table of loads and queries, then random triangles with random
// queries and noise. Each phase sets the wrap setting and idle pattern; every
// result word is checked against a table value or an exact wide-integer predictor.
// ----------------------------------------------------------------------------
module barycentric_texcoord_interp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 20000000;
    localparam int  RAND_WORDS   = 1550;
    localparam int  NUM_PHASES   = 5;
    localparam int  FRAC         = 16;
    localparam int  SETTLE       = 40;

    typedef logic signed [255:0] big_t;

    typedef struct {
        btci_pkg::mode_t mode;
        logic [31:0]     x, y, z, u, v;
        bit              typed;
        logic [31:0]     eu, ev;
        bit              eok;
    } word_row_t;

    typedef struct {
        logic [31:0] u, v;
        bit          ok;
    } texcoord_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic cfg_data;

    btci_item_if   item_ch();
    btci_result_if res_ch();

    barycentric_texcoord_interp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (res_ch),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    logic [31:0] vert_mem [15];
    logic [2:0]  vert_mask;
    bit          wrap_on;
    texcoord_t   texcoord_q [$];
    word_row_t   dir_rows [$];
    int          fails;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("barycentric_texcoord_interp test failed");
                $finish;
            end
        end
    end

    function automatic big_t sx(input logic [31:0] w);
        return {{224{w[31]}}, w};
    endfunction

    // Round num/den to nearest (ties up), add tc, then wrap or clamp.
    function automatic logic [31:0] round_add(input big_t num, input big_t den,
                                              input logic [31:0] tc);
        big_t t, d2, q, res;
        t  = num + num + den;
        d2 = den + den;
        q  = t / d2;
        if (t < 0 && q * d2 != t)
            q = q - 1;
        res = q + sx(tc);
        if (wrap_on)
            return {{(32-FRAC){1'b0}}, res[FRAC-1:0]};
        if (res > sx(32'h7fffffff))
            return 32'h7fffffff;
        if (res < sx(32'h80000000))
            return 32'h80000000;
        return res[31:0];
    endfunction

    function automatic texcoord_t interp_texcoord(input logic [31:0] px,
                                                  input logic [31:0] py,
                                                  input logic [31:0] pz);
        big_t      ab[3], ac[3], ap[3], bp[3], cp[3], n[3], x[3];
        big_t      p[3];
        big_t      den, pa, pb, ta, tb, tc;
        texcoord_t r;
        r.u = '0;
        r.v = '0;
        r.ok = 1'b0;
        if (vert_mask != 3'b111)
            return r;
        p[0] = sx(px);
        p[1] = sx(py);
        p[2] = sx(pz);
        for (int k = 0; k < 3; k++)
        begin
            ab[k] = sx(vert_mem[5 + k]) - sx(vert_mem[k]);
            ac[k] = sx(vert_mem[10 + k]) - sx(vert_mem[k]);
            ap[k] = sx(vert_mem[k]) - p[k];
            bp[k] = sx(vert_mem[5 + k]) - p[k];
            cp[k] = sx(vert_mem[10 + k]) - p[k];
        end
        n[0] = ab[1] * ac[2] - ab[2] * ac[1];
        n[1] = ab[2] * ac[0] - ab[0] * ac[2];
        n[2] = ab[0] * ac[1] - ab[1] * ac[0];
        den = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        if (den == 0)
            return r;
        x[0] = bp[1] * cp[2] - bp[2] * cp[1];
        x[1] = bp[2] * cp[0] - bp[0] * cp[2];
        x[2] = bp[0] * cp[1] - bp[1] * cp[0];
        pa = n[0] * x[0] + n[1] * x[1] + n[2] * x[2];
        x[0] = cp[1] * ap[2] - cp[2] * ap[1];
        x[1] = cp[2] * ap[0] - cp[0] * ap[2];
        x[2] = cp[0] * ap[1] - cp[1] * ap[0];
        pb = n[0] * x[0] + n[1] * x[1] + n[2] * x[2];
        for (int k = 0; k < 2; k++)
        begin
            ta = sx(vert_mem[3 + k]);
            tb = sx(vert_mem[8 + k]);
            tc = sx(vert_mem[13 + k]);
            if (k == 0)
                r.u = round_add(pa * (ta - tc) + pb * (tb - tc), den, vert_mem[13]);
            else
                r.v = round_add(pa * (ta - tc) + pb * (tb - tc), den, vert_mem[14]);
        end
        r.ok = 1'b1;
        return r;
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097152)) - 1048576);
            2: return 32'($signed($urandom_range(33554432)) - 16777216);
            3:
            begin
                case ($urandom_range(3))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    default: return 32'hffffffff;
                endcase
            end
            default: return 32'($signed($urandom_range(655360)) - 327680);
        endcase
    endfunction

    task automatic send_word(input word_row_t w);
        int        gap;
        texcoord_t e;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.mode  <= w.mode;
        item_ch.pos_x <= w.x;
        item_ch.pos_y <= w.y;
        item_ch.pos_z <= w.z;
        item_ch.tex_u <= w.u;
        item_ch.tex_v <= w.v;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (w.mode == btci_pkg::MODE_QUERY)
        begin
            if (w.typed)
            begin
                e.u  = w.eu;
                e.v  = w.ev;
                e.ok = w.eok;
            end
            else
                e = interp_texcoord(w.x, w.y, w.z);
            texcoord_q.push_back(e);
        end
        else
        begin
            vert_mem[w.mode * 5 + 0] = w.x;
            vert_mem[w.mode * 5 + 1] = w.y;
            vert_mem[w.mode * 5 + 2] = w.z;
            vert_mem[w.mode * 5 + 3] = w.u;
            vert_mem[w.mode * 5 + 4] = w.v;
            vert_mask[w.mode] = 1'b1;
        end
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (texcoord_q.size() != 0)
            @(posedge clk);
        // a vertex load gives no word back; let it finish
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_wrap(input bit val);
        cfg_write <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        wrap_on = val;
    endtask

    task automatic add_row(input btci_pkg::mode_t m, input logic [31:0] x,
                           input logic [31:0] y,
                           input logic [31:0] z, input logic [31:0] u,
                           input logic [31:0] v, input bit typed,
                           input logic [31:0] eu, input logic [31:0] ev,
                           input bit eok);
        word_row_t r;
        r.mode = m; r.x = x; r.y = y; r.z = z; r.u = u; r.v = v;
        r.typed = typed; r.eu = eu; r.ev = ev; r.eok = eok;
        dir_rows.push_back(r);
    endtask

    task automatic rand_word(input btci_pkg::mode_t m, output word_row_t w);
        w.mode = m;
        w.x = rnd_coord();
        w.y = rnd_coord();
        w.z = rnd_coord();
        w.u = rnd_coord();
        w.v = rnd_coord();
        w.typed = 1'b0;
        w.eu = '0; w.ev = '0; w.eok = 1'b0;
    endtask

    // Receive side: check each accepted word, redraw ready every cycle.
    initial
    begin
        texcoord_t e;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (texcoord_q.size() == 0)
                begin
                    $display("%0t: unexpected result u=%h v=%h ok=%b", $time,
                             res_ch.out_u, res_ch.out_v, res_ch.ok);
                    fails++;
                end
                else
                begin
                    e = texcoord_q.pop_front();
                    if (res_ch.out_u !== e.u)
                    begin
                        $display("%0t: out_u expected %h actual %h", $time, e.u, res_ch.out_u);
                        fails++;
                    end
                    if (res_ch.out_v !== e.v)
                    begin
                        $display("%0t: out_v expected %h actual %h", $time, e.v, res_ch.out_v);
                        fails++;
                    end
                    if (res_ch.ok !== e.ok)
                    begin
                        $display("%0t: ok expected %b actual %b", $time, e.ok, res_ch.ok);
                        fails++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int              send_pct [NUM_PHASES] = '{0, 60, 0, 10, 0};
        int              recv_pct [NUM_PHASES] = '{0, 0, 60, 10, 0};
        bit              wrap_set [NUM_PHASES] = '{0, 1, 0, 1, 1};
        int              sent;
        int              nq;
        word_row_t       w;
        btci_pkg::mode_t order [3];

        fails = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        vert_mask = '0;
        wrap_on = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.mode = btci_pkg::MODE_A;
        item_ch.pos_x = '0;
        item_ch.pos_y = '0;
        item_ch.pos_z = '0;
        item_ch.tex_u = '0;
        item_ch.tex_v = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(btci_pkg::MODE_QUERY, 0, 0, 0, 32'hffffffff, 32'hffffffff, 1, 0, 0, 0);
        add_row(btci_pkg::MODE_A, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_B, 32'h10000, 0, 0, 32'h10000, 0, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(btci_pkg::MODE_C, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_QUERY, 32'h8000, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(btci_pkg::MODE_C, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 1, 0, 0, 1);
        add_row(btci_pkg::MODE_QUERY, 0, 32'h10000, 0, 0, 0, 1, 0, 32'h10000, 1);
        add_row(btci_pkg::MODE_QUERY, 32'h5555, 32'h5555, 32'h1234, 0, 0, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_C, 0, 32'h10000, 0, 32'hffffc000, 32'h7fffffff,
                0, 0, 0, 0);
        add_row(btci_pkg::MODE_QUERY, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                0, 0, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_A, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_B, 32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_C, 32'h0, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_QUERY, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                0, 0, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_QUERY, 32'h80000000, 32'h80000000, 32'h80000000,
                0, 0, 0, 0, 0, 0);
        add_row(btci_pkg::MODE_QUERY, 0, 0, 0, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0);
        foreach (dir_rows[i])
            send_word(dir_rows[i]);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_wrap(wrap_set[ph]);
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            sent = 0;
            while (sent < RAND_WORDS / NUM_PHASES)
            begin
                if ($urandom_range(9) < 7)
                begin
                    // well-formed: three loads in random order, then at most one query
                    order[0] = btci_pkg::MODE_A;
                    order[1] = btci_pkg::MODE_B;
                    order[2] = btci_pkg::MODE_C;
                    order.shuffle();
                    for (int k = 0; k < 3; k++)
                    begin
                        rand_word(order[k], w);
                        send_word(w);
                    end
                    sent += 3;
                    nq = ($urandom_range(3) == 0) ? 1 : 0;
                    for (int k = 0; k < nq; k++)
                    begin
                        rand_word(btci_pkg::MODE_QUERY, w);
                        if ($urandom_range(1))
                        begin
                            w.x = vert_mem[$urandom_range(2) * 5 + 0];
                            w.y = vert_mem[5 + 1] + 32'($urandom_range(65535));
                        end
                        send_word(w);
                        sent++;
                    end
                end
                else
                begin
                    rand_word(btci_pkg::mode_t'($urandom_range(3)), w);
                    if (w.mode == btci_pkg::MODE_QUERY && $urandom_range(1))
                        w.mode = btci_pkg::MODE_B;
                    send_word(w);
                    sent++;
                end
                if (ph == 2 && sent >= 100 && sent < 104)
                begin
                    // hold off until every outstanding word has come back
                    item_ch.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (texcoord_q.size() != 0);
                end
            end
            drain();
        end

        if (fails == 0)
            $display("barycentric_texcoord_interp test passed");
        else
            $display("barycentric_texcoord_interp test failed");
        $finish;
    end

endmodule
`default_nettype wire
